>>> rtl/qrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadratic root solver package
// Shared result codes, saturation limits and the per-item status record.
// ----------------------------------------------------------------------------
package qrs_pkg;

   localparam int ROOT_WIDTH = 33;

   localparam logic [1:0] CNT_NONE = 2'd0;
   localparam logic [1:0] CNT_ONE  = 2'd1;
   localparam logic [1:0] CNT_TWO  = 2'd2;

   localparam logic [63:0] POS_LIMIT = 64'h0000_0000_FFFF_FFFF;
   localparam logic [63:0] NEG_LIMIT = 64'h0000_0001_0000_0000;

   typedef struct packed {
      logic [1:0] root_count;
      logic       bad_leading;
   } meta_type;

endpackage

>>> rtl/qrs_disc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Discriminant pipeline
// Three stages: magnitudes, products, then b*b - 4ac as magnitude and sign.
// ----------------------------------------------------------------------------
module qrs_disc #(
   parameter int W = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  logic signed [W-1:0] coef_a,
   input  logic signed [W-1:0] coef_b,
   input  logic signed [W-1:0] coef_c,
   output logic                out_valid,
   output logic [2*W:0]        disc,
   output logic                disc_neg,
   output logic signed [W-1:0] a_out,
   output logic signed [W-1:0] b_out,
   output logic                a_zero
);
   logic [2:0]          vld_ff;
   logic signed [W-1:0] a_ff [3];
   logic signed [W-1:0] b_ff [3];
   logic [W-1:0]        ua_ff, ub_ff, uc_ff;
   logic                add1_ff, add2_ff;
   logic [2*W-1:0]      bb_ff, ac_ff;
   logic [2*W:0]        disc_ff;
   logic                neg_ff;
   logic [2*W+1:0]      bb_x, ac4_x;
   logic [2*W+1:0]      sum_in, dif_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[1:0], in_valid};
      end
   end

   assign bb_x   = (2*W+2)'(bb_ff);
   assign ac4_x  = {ac_ff, 2'b00};
   assign sum_in = bb_x + ac4_x;
   assign dif_in = bb_x - ac4_x;

   always_ff @(posedge clock) begin
      if (adv) begin
         a_ff[0] <= coef_a;
         b_ff[0] <= coef_b;
         ua_ff   <= coef_a[W-1] ? W'(-coef_a) : W'(coef_a);
         ub_ff   <= coef_b[W-1] ? W'(-coef_b) : W'(coef_b);
         uc_ff   <= coef_c[W-1] ? W'(-coef_c) : W'(coef_c);
         add1_ff <= (coef_a[W-1] != coef_c[W-1]) && (coef_c != '0);
         a_ff[1] <= a_ff[0];
         b_ff[1] <= b_ff[0];
         bb_ff   <= ub_ff * ub_ff;
         ac_ff   <= ua_ff * uc_ff;
         add2_ff <= add1_ff;
         a_ff[2] <= a_ff[1];
         b_ff[2] <= b_ff[1];
         if (add2_ff) begin
            disc_ff <= sum_in[2*W:0];
            neg_ff  <= 1'b0;
         end else begin
            disc_ff <= dif_in[2*W:0];
            neg_ff  <= ac4_x > bb_x;
         end
      end
   end

   assign out_valid = vld_ff[2];
   assign disc      = disc_ff;
   assign disc_neg  = neg_ff;
   assign a_out     = a_ff[2];
   assign b_out     = b_ff[2];
   assign a_zero    = (a_ff[2] == '0);
endmodule

>>> rtl/qrs_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One root bit per stage; the final remainder tells whether the root is exact.
// ----------------------------------------------------------------------------
module qrs_sqrt #(
   parameter int RW     = 33,
   parameter int SIDE_W = 35
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  logic [2*RW-1:0]   rad,
   input  logic [SIDE_W-1:0] side_in,
   output logic              out_valid,
   output logic [RW-1:0]     root,
   output logic              exact,
   output logic [SIDE_W-1:0] side_out
);
   logic [RW-1:0]     vld_ff;
   logic [2*RW-1:0]   rad_ff  [RW];
   logic [RW-1:0]     root_ff [RW];
   logic [RW+1:0]     rem_ff  [RW];
   logic [SIDE_W-1:0] side_ff [RW];

   for (genvar k = 0; k < RW; k++) begin : g_stage
      logic              vld_p;
      logic [2*RW-1:0]   rad_p;
      logic [RW-1:0]     root_p;
      logic [RW+1:0]     rem_p;
      logic [SIDE_W-1:0] side_p;
      logic [RW+1:0]     rem_t, trial;
      logic              ge;

      if (k == 0) begin : g_first
         assign vld_p  = in_valid;
         assign rad_p  = rad;
         assign root_p = '0;
         assign rem_p  = '0;
         assign side_p = side_in;
      end else begin : g_next
         assign vld_p  = vld_ff[k-1];
         assign rad_p  = rad_ff[k-1];
         assign root_p = root_ff[k-1];
         assign rem_p  = rem_ff[k-1];
         assign side_p = side_ff[k-1];
      end

      assign rem_t = {rem_p[RW-1:0], rad_p[2*RW-1 -: 2]};
      assign trial = {root_p, 2'b01};
      assign ge    = rem_t >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= vld_p;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rad_ff[k]  <= rad_p << 2;
            root_ff[k] <= {root_p[RW-2:0], ge};
            rem_ff[k]  <= ge ? rem_t - trial : rem_t;
            side_ff[k] <= side_p;
         end
      end
   end

   assign out_valid = vld_ff[RW-1];
   assign root      = root_ff[RW-1];
   assign exact     = (rem_ff[RW-1] == '0);
   assign side_out  = side_ff[RW-1];
endmodule

>>> rtl/qrs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring division with one quotient bit per stage.
// ----------------------------------------------------------------------------
module qrs_div #(
   parameter int NW     = 35,
   parameter int DW     = 17,
   parameter int SIDE_W = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  logic [NW-1:0]     dividend,
   input  logic [DW-1:0]     divisor,
   input  logic [SIDE_W-1:0] side_in,
   output logic              out_valid,
   output logic [NW-1:0]     quotient,
   output logic [SIDE_W-1:0] side_out
);
   logic [NW-1:0]     vld_ff;
   logic [NW-1:0]     dvd_ff  [NW];
   logic [NW-1:0]     quo_ff  [NW];
   logic [DW-1:0]     rem_ff  [NW];
   logic [DW-1:0]     dvs_ff  [NW];
   logic [SIDE_W-1:0] side_ff [NW];

   for (genvar k = 0; k < NW; k++) begin : g_stage
      logic              vld_p;
      logic [NW-1:0]     dvd_p, quo_p;
      logic [DW-1:0]     rem_p, dvs_p;
      logic [SIDE_W-1:0] side_p;
      logic [DW:0]       rem_t, dvs_x, rem_s;
      logic              ge;

      if (k == 0) begin : g_first
         assign vld_p  = in_valid;
         assign dvd_p  = dividend;
         assign quo_p  = '0;
         assign rem_p  = '0;
         assign dvs_p  = divisor;
         assign side_p = side_in;
      end else begin : g_next
         assign vld_p  = vld_ff[k-1];
         assign dvd_p  = dvd_ff[k-1];
         assign quo_p  = quo_ff[k-1];
         assign rem_p  = rem_ff[k-1];
         assign dvs_p  = dvs_ff[k-1];
         assign side_p = side_ff[k-1];
      end

      assign rem_t = {rem_p, dvd_p[NW-1]};
      assign dvs_x = {1'b0, dvs_p};
      assign ge    = rem_t >= dvs_x;
      assign rem_s = ge ? rem_t - dvs_x : rem_t;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= vld_p;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dvd_ff[k]  <= dvd_p << 1;
            quo_ff[k]  <= {quo_p[NW-2:0], ge};
            rem_ff[k]  <= rem_s[DW-1:0];
            dvs_ff[k]  <= dvs_p;
            side_ff[k] <= side_p;
         end
      end
   end

   assign out_valid = vld_ff[NW-1];
   assign quotient  = quo_ff[NW-1];
   assign side_out  = side_ff[NW-1];
endmodule

>>> rtl/quadratic_root_solver.sv
// Throughput: one item per cycle; the whole pipeline advances unless the result stalls.
// Depth is set mostly by the square root (one bit per stage) and the two parallel dividers (one bit each).
// Reset is synchronous and clears all valid bits; no clearing pass is needed.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadratic root solver
// Finds the real roots of a*x^2 + b*x + c in signed fixed point, truncated.
// ----------------------------------------------------------------------------
module quadratic_root_solver #(
   parameter int COEF_WIDTH = 16,
   parameter int FRAC_BITS  = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [COEF_WIDTH-1:0] req_coef_a,
   input  logic signed [COEF_WIDTH-1:0] req_coef_b,
   input  logic signed [COEF_WIDTH-1:0] req_coef_c,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [1:0]                   rsp_root_count,
   output logic signed [qrs_pkg::ROOT_WIDTH-1:0] rsp_root_first,
   output logic signed [qrs_pkg::ROOT_WIDTH-1:0] rsp_root_second,
   output logic                         rsp_bad_leading
);
   import qrs_pkg::*;

   localparam int W      = COEF_WIDTH;
   localparam int F      = FRAC_BITS;
   localparam int RW     = W + F + 1;
   localparam int NW     = W + F + 3;
   localparam int DVW    = W + 1;
   localparam int SQ_SW  = 2 * W + $bits(meta_type);
   localparam int DP_SW  = 1 + $bits(meta_type);

   logic                adv;
   logic                dv_valid, dv_neg, dv_azero;
   logic [2*W:0]        dv_disc;
   logic signed [W-1:0] dv_a, dv_b;
   meta_type            dv_meta;

   logic                sq_valid, sq_exact;
   logic [RW-1:0]       sq_root;
   logic [SQ_SW-1:0]    sq_side;
   logic signed [W-1:0] sq_a, sq_b;
   meta_type            sq_meta;

   logic signed [NW-1:0] nb_in, s_in, mp_in, mm_in;

   logic                prep_valid_ff;
   logic [NW-1:0]       up_ff, um_ff;
   logic [DVW-1:0]      dvs_ff;
   logic                negp_ff, negm_ff;
   meta_type            prep_meta_ff;

   logic                dp_valid, dm_valid;
   logic [NW-1:0]       qp, qm;
   logic [DP_SW-1:0]    dp_side;
   logic                dm_side;
   meta_type            dp_meta;

   logic                            rsp_valid_ff;
   logic [1:0]                      count_ff;
   logic [ROOT_WIDTH-1:0]           first_ff, second_ff;
   logic                            bad_ff;

   function automatic logic [NW-1:0] mag_num(input logic signed [NW-1:0] m,
                                             input logic frac);
      logic [NW-1:0] r;
      if (!m[NW-1]) begin
         r = m;
      end else if (frac) begin
         r = NW'(-m - NW'(1));
      end else begin
         r = NW'(-m);
      end
      return r;
   endfunction

   function automatic logic [ROOT_WIDTH-1:0] sat_root(input logic [NW-1:0] q,
                                                     input logic neg);
      logic [63:0] q64;
      logic [63:0] n64;
      logic [ROOT_WIDTH-1:0] r;
      q64 = 64'(q);
      n64 = -q64;
      if (neg) begin
         r = (q64 > NEG_LIMIT) ? NEG_LIMIT[ROOT_WIDTH-1:0] : n64[ROOT_WIDTH-1:0];
      end else begin
         r = (q64 > POS_LIMIT) ? POS_LIMIT[ROOT_WIDTH-1:0] : q64[ROOT_WIDTH-1:0];
      end
      return r;
   endfunction

   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = rsp_valid_ff && rsp_stall;

   qrs_disc #(.W(W)) u_disc (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .coef_a    (req_coef_a),
      .coef_b    (req_coef_b),
      .coef_c    (req_coef_c),
      .out_valid (dv_valid),
      .disc      (dv_disc),
      .disc_neg  (dv_neg),
      .a_out     (dv_a),
      .b_out     (dv_b),
      .a_zero    (dv_azero)
   );

   always_comb begin
      dv_meta.bad_leading = dv_azero;
      if (dv_azero || dv_neg) begin
         dv_meta.root_count = CNT_NONE;
      end else if (dv_disc == '0) begin
         dv_meta.root_count = CNT_ONE;
      end else begin
         dv_meta.root_count = CNT_TWO;
      end
   end

   qrs_sqrt #(.RW(RW), .SIDE_W(SQ_SW)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (dv_valid),
      .rad       ((2*RW)'(dv_disc) << (2*F)),
      .side_in   ({dv_a, dv_b, dv_meta}),
      .out_valid (sq_valid),
      .root      (sq_root),
      .exact     (sq_exact),
      .side_out  (sq_side)
   );

   assign {sq_a, sq_b, sq_meta} = sq_side;

   assign nb_in = -(NW'(sq_b) <<< F);
   assign s_in  = NW'(sq_root);
   assign mp_in = nb_in + s_in;
   assign mm_in = nb_in - s_in - (sq_exact ? NW'(0) : NW'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else if (adv) begin
         prep_valid_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         up_ff        <= mag_num(mp_in, !sq_exact);
         um_ff        <= mag_num(mm_in, !sq_exact);
         negp_ff      <= mp_in[NW-1] ^ sq_a[W-1];
         negm_ff      <= mm_in[NW-1] ^ sq_a[W-1];
         dvs_ff       <= {(sq_a[W-1] ? W'(-sq_a) : W'(sq_a)), 1'b0};
         prep_meta_ff <= sq_meta;
      end
   end

   qrs_div #(.NW(NW), .DW(DVW), .SIDE_W(DP_SW)) u_div_plus (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (prep_valid_ff),
      .dividend  (up_ff),
      .divisor   (dvs_ff),
      .side_in   ({negp_ff, prep_meta_ff}),
      .out_valid (dp_valid),
      .quotient  (qp),
      .side_out  (dp_side)
   );

   qrs_div #(.NW(NW), .DW(DVW), .SIDE_W(1)) u_div_minus (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (prep_valid_ff),
      .dividend  (um_ff),
      .divisor   (dvs_ff),
      .side_in   (negm_ff),
      .out_valid (dm_valid),
      .quotient  (qm),
      .side_out  (dm_side)
   );

   assign dp_meta = dp_side[$bits(meta_type)-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dp_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         count_ff  <= dp_meta.root_count;
         bad_ff    <= dp_meta.bad_leading;
         first_ff  <= (dp_meta.root_count != CNT_NONE) ?
                      sat_root(qp, dp_side[DP_SW-1]) : '0;
         second_ff <= (dp_meta.root_count == CNT_TWO) ? sat_root(qm, dm_side) : '0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_root_count  = count_ff;
   assign rsp_root_first  = first_ff;
   assign rsp_root_second = second_ff;
   assign rsp_bad_leading = bad_ff;

   a_div_in_step: assert property (@(posedge clock) disable iff (reset)
      dp_valid == dm_valid)
      else $error("root dividers out of step");

   a_bad_no_roots: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_leading |-> rsp_root_count == CNT_NONE)
      else $error("roots reported with zero leading coefficient");

   a_absent_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_root_count != CNT_TWO |-> rsp_root_second == '0)
      else $error("absent second root is not zero");

   a_no_roots_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_root_count == CNT_NONE |-> rsp_root_first == '0)
      else $error("absent first root is not zero");
endmodule

>>> sim/tb_quadratic_root_solver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadratic root solver testbench
// Streams coefficient triples through the solver with random gaps and result
// stalls. Each accepted triple is solved exactly in the testbench, and every
// result is compared field by field, in order, with the predicted roots.
// ----------------------------------------------------------------------------
module tb_quadratic_root_solver;
   import qrs_pkg::*;

   localparam int COEF_W = 16;
   localparam int FRAC_W = 16;
   localparam int RANDOM_ITEMS = 1930;
   localparam int STALL_LIMIT = 5000;

   typedef struct {
      logic signed [COEF_W-1:0] a;
      logic signed [COEF_W-1:0] b;
      logic signed [COEF_W-1:0] c;
   } coef_set_type;

   typedef struct {
      logic [1:0]                   count;
      logic signed [ROOT_WIDTH-1:0] first;
      logic signed [ROOT_WIDTH-1:0] second;
      logic                         bad;
   } roots_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic signed [COEF_W-1:0] req_coef_a = '0;
   logic signed [COEF_W-1:0] req_coef_b = '0;
   logic signed [COEF_W-1:0] req_coef_c = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [1:0] rsp_root_count;
   logic signed [ROOT_WIDTH-1:0] rsp_root_first;
   logic signed [ROOT_WIDTH-1:0] rsp_root_second;
   logic rsp_bad_leading;

   coef_set_type pending_coefs[$];
   roots_type expected_roots[$];
   int errors = 0;
   int sent_count = 0;
   int solved_count[4];
   int quiet_cycles = 0;
   bit stimulus_done = 0;

   quadratic_root_solver #(.COEF_WIDTH(COEF_W), .FRAC_BITS(FRAC_W)) dut (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   // Truncates (m + f) / d toward zero, where 0 <= f < 1 and f > 0 when frac is set.
   function automatic longint div_toward_zero(longint m, bit frac, longint d);
      if (d < 0) begin
         d = -d;
         m = frac ? -m - 1 : -m;
      end
      if (m >= 0) return m / d;
      return frac ? -((-m - 1) / d) : -((-m) / d);
   endfunction

   function automatic logic signed [ROOT_WIDTH-1:0] clamp_root(longint v);
      if (v > 64'sd4294967295) v = 64'sd4294967295;
      if (v < -64'sd4294967296) v = -64'sd4294967296;
      return v[ROOT_WIDTH-1:0];
   endfunction

   function automatic roots_type solve_quadratic(coef_set_type k);
      roots_type r;
      longint a, b, c, disc, nb, d, s, plus, minus;
      logic [127:0] scaled, trial;
      bit exact;
      a = k.a;
      b = k.b;
      c = k.c;
      r = '{CNT_NONE, '0, '0, 1'b0};
      if (a == 0) begin
         r.bad = 1'b1;
         return r;
      end
      disc = b * b - 4 * a * c;
      if (disc < 0) return r;
      d = 2 * a;
      nb = -b * (64'sd1 <<< FRAC_W);
      if (disc == 0) begin
         r.count = CNT_ONE;
         r.first = clamp_root(div_toward_zero(nb, 1'b0, d));
         return r;
      end
      scaled = 128'(disc) << (2 * FRAC_W);
      trial = '0;
      for (int i = 40; i >= 0; i--) begin
         if ((trial | (128'd1 << i)) * (trial | (128'd1 << i)) <= scaled)
            trial = trial | (128'd1 << i);
      end
      exact = (trial * trial == scaled);
      s = longint'(trial);
      plus = div_toward_zero(nb + s, !exact, d);
      minus = exact ? div_toward_zero(nb - s, 1'b0, d) : div_toward_zero(nb - s - 1, 1'b1, d);
      r.count = CNT_TWO;
      r.first = clamp_root(plus);
      r.second = clamp_root(minus);
      return r;
   endfunction

   function automatic bit idle_now(int n);
      if (n >= 700 && n < 1000) return 0;
      return $urandom_range(99) < 17;
   endfunction

   task automatic add_coefs(int a, int b, int c);
      coef_set_type k;
      k.a = a[COEF_W-1:0];
      k.b = b[COEF_W-1:0];
      k.c = c[COEF_W-1:0];
      pending_coefs.push_back(k);
   endtask

   initial begin
      int a, kr, pick;
      add_coefs(0, 5, 7);
      add_coefs(0, 0, 0);
      add_coefs(1, 0, 1);
      add_coefs(1, 2, 1);
      add_coefs(-3, 12, -12);
      add_coefs(1, -3, 2);
      add_coefs(1, 0, -2);
      add_coefs(-1, 1, 1);
      add_coefs(1, 0, 0);
      add_coefs(-32768, -32768, -32768);
      add_coefs(32767, 32767, 32767);
      add_coefs(1, -32768, -32768);
      add_coefs(1, 32767, -32768);
      add_coefs(-32768, 32767, 32767);
      add_coefs(32767, -32768, 0);
      add_coefs(-1, -32768, 32767);
      add_coefs(1, -32768, 32767);
      add_coefs(2, 3, -5);
      add_coefs(-7, 0, 0);
      add_coefs(32767, 0, -32768);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         pick = $urandom_range(99);
         if (pick < 15) begin
            do a = $signed($urandom_range(200)) - 100; while (a == 0);
            kr = $signed($urandom_range(36)) - 18;
            add_coefs(a, 2 * a * kr, a * kr * kr);
         end else if (pick < 20) begin
            add_coefs(0, $urandom, $urandom);
         end else if (pick < 40) begin
            add_coefs($signed($urandom_range(20)) - 10, $urandom, $signed($urandom_range(200)) - 100);
         end else begin
            add_coefs($urandom, $urandom, $urandom);
         end
      end
      repeat (10) @(posedge clock);
      reset <= 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            expected_roots.push_back(solve_quadratic('{req_coef_a, req_coef_b, req_coef_c}));
            sent_count++;
         end
         if (pending_coefs.size() > 0 && !idle_now(sent_count)) begin
            coef_set_type k;
            k = pending_coefs.pop_front();
            req_valid <= 1;
            req_coef_a <= k.a;
            req_coef_b <= k.b;
            req_coef_c <= k.c;
         end else begin
            req_valid <= 0;
            if (pending_coefs.size() == 0 && req_valid) stimulus_done = 1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_roots.size() == 0) begin
               $error("result with no item outstanding");
               errors++;
            end else begin
               roots_type e;
               e = expected_roots.pop_front();
               solved_count[e.bad ? 3 : e.count]++;
               if (rsp_root_count !== e.count) begin
                  $error("root_count expected %0d got %0d", e.count, rsp_root_count);
                  errors++;
               end
               if (rsp_root_first !== e.first) begin
                  $error("root_first expected %0d got %0d", e.first, rsp_root_first);
                  errors++;
               end
               if (rsp_root_second !== e.second) begin
                  $error("root_second expected %0d got %0d", e.second, rsp_root_second);
                  errors++;
               end
               if (rsp_bad_leading !== e.bad) begin
                  $error("bad_leading expected %0d got %0d", e.bad, rsp_bad_leading);
                  errors++;
               end
            end
         end
         rsp_stall <= idle_now(sent_count);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles > STALL_LIMIT) begin
            $display("tb_quadratic_root_solver NOT OK");
            $finish;
         end
      end
   end

   initial begin
      wait (stimulus_done);
      wait (expected_roots.size() == 0);
      repeat (100) @(posedge clock);
      $display("Solved %0d items: %0d without real roots, %0d double, %0d with two roots,",
               sent_count, solved_count[0], solved_count[1], solved_count[2]);
      $display("and %0d with a zero leading coefficient.", solved_count[3]);
      if (errors == 0) begin
         $display("tb_quadratic_root_solver OK");
      end else begin
         $display("tb_quadratic_root_solver NOT OK");
      end
      $finish;
   end

endmodule
